[hdl/ceq_pkg.sv]
// package for the coalescing event queue
// holds the mode, status, cfg and fsm codes; no dependencies
package ceq_pkg;

  localparam logic [1:0] MODE_ENQ    = 2'd0;
  localparam logic [1:0] MODE_EXPIRE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [2:0] ST_UNKNOWN   = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_QUEUED    = 3'd2;
  localparam logic [2:0] ST_COALESCED = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  localparam logic [0:0] CFG_CAPACITY = 1'd0;
  localparam logic [0:0] CFG_WINDOW   = 1'd1;

  localparam logic [2:0] FSM_IDLE   = 3'd0;
  localparam logic [2:0] FSM_READ   = 3'd1;
  localparam logic [2:0] FSM_EXPIRE = 3'd2;
  localparam logic [2:0] FSM_TRIM   = 3'd3;
  localparam logic [2:0] FSM_TAIL   = 3'd4;
  localparam logic [2:0] FSM_OUT    = 3'd5;

endpackage

[hdl/coalescing_event_queue.sv]
// coalescing event queue: bounded event fifo that merges repeats of the newest entry
// entries live in synchronous memories (registered read); uses ceq_pkg
//
// channel   dir  handshake        payload
// s_axis    in   tvalid/tready    tdata: mode,perception_id,perception_known,keys,tick_ms
// m_axis    out  tvalid/tready    tdata: status,sequence_res,count,latest fields
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// query, clear and a rejected or merged enqueue go from accept to result through a memory
// read of the newest entry, a compare/modify step in FSM_READ and a reread of the tail for
// the report. an append adds a trim state that drops oldest entries down to the capacity.
// expire reads the front entry and pops one entry per cycle while it is older than the tick.
// the result sits in an output register; a new beat is taken the cycle after it has left.
// reset empties the queue and sets the sequence counter to one; no clearing pass.
module coalescing_event_queue
  import ceq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int TICK_BITS   = 48,
  parameter int SEQ_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // mode, perception_id, perception_known, source, other, victim, item, tick_ms
  input  logic [((2+16+1+4*KEY_BITS+TICK_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status, sequence_res, count, latest_valid, latest_sequence, latest_repeats
  output logic [((3+SEQ_BITS+$clog2(QUEUE_DEPTH+1)+1+SEQ_BITS+32+7)/8)*8-1:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = 16 + 4*KEY_BITS;
  localparam int OW = ((3+SEQ_BITS+CW+1+SEQ_BITS+32+7)/8)*8;
  localparam int OU = 3+SEQ_BITS+CW+1+SEQ_BITS+32;
  localparam logic [31:0] REP_MAX = '1;

  // entry memories: identity (id+keys), ticks, sequence/repeats
  logic [EW-1:0]        mem_id   [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] mem_last [QUEUE_DEPTH];
  logic [SEQ_BITS-1:0]  mem_seq  [QUEUE_DEPTH];
  logic [31:0]          mem_rep  [QUEUE_DEPTH];

  logic [EW-1:0]        rd_id;
  logic [TICK_BITS-1:0] rd_last;
  logic [SEQ_BITS-1:0]  rd_seq;
  logic [31:0]          rd_rep;

  logic [2:0]  state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SEQ_BITS-1:0] nseq_q, nseq_d;
  logic [4:0]  cap_q;
  logic [15:0] win_q;
  logic [1:0]  mode_q;
  logic        known_q;
  logic [EW-1:0] key_q;
  logic [TICK_BITS-1:0] tick_q;
  logic [2:0]  status_q, status_d;
  logic [SEQ_BITS-1:0] sres_q, sres_d;
  logic        ovalid_q;
  logic [OU-1:0] odata_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en, wr_full;
  logic [AW-1:0] wr_addr;
  logic [TICK_BITS-1:0] wr_last;
  logic [SEQ_BITS-1:0]  wr_seq;
  logic [31:0]          wr_rep;

  logic [CW-1:0] cap_eff;
  logic [TICK_BITS:0] lim;
  logic accept;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = CW'(h) + p;
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  assign s_axis_tready = (state_q == FSM_IDLE) && !ovalid_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = OW'(odata_q);

  always_comb begin
    if (cap_q == 5'd0) cap_eff = CW'(1);
    else if (32'(cap_q) > 32'(QUEUE_DEPTH)) cap_eff = CW'(QUEUE_DEPTH);
    else cap_eff = CW'(cap_q);
  end

  assign lim = {1'b0, rd_last} + (TICK_BITS+1)'(win_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_last[wr_addr] <= wr_last;
      mem_rep[wr_addr]  <= wr_rep;
      if (wr_full) begin
        mem_id[wr_addr]  <= key_q;
        mem_seq[wr_addr] <= wr_seq;
      end
    end
    if (rd_en) begin
      rd_id   <= mem_id[rd_addr];
      rd_last <= mem_last[rd_addr];
      rd_seq  <= mem_seq[rd_addr];
      rd_rep  <= mem_rep[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q; head_d = head_q; cnt_d = cnt_q; nseq_d = nseq_q;
    status_d = status_q; sres_d = sres_q;
    rd_en = 1'b0; rd_addr = slot(head_q, cnt_q - CW'(1));
    wr_en = 1'b0; wr_full = 1'b0; wr_addr = slot(head_q, cnt_q - CW'(1));
    wr_last = tick_q; wr_seq = nseq_q; wr_rep = 32'd1;
    unique case (state_q)
      FSM_IDLE: ;
      FSM_READ: begin
        // tail entry (for enqueue) was read last cycle
        status_d = ST_DONE; sres_d = '0;
        unique case (mode_q)
          MODE_ENQ: begin
            if (!known_q) begin
              status_d = ST_UNKNOWN; state_d = FSM_TAIL;
            end else if (key_q[16 +: 3*KEY_BITS] == '0) begin
              status_d = ST_EMPTY; state_d = FSM_TAIL;
            end else if (cnt_q != '0 && rd_id == key_q &&
                         {1'b0, tick_q} <= lim) begin
              wr_en = 1'b1; wr_last = tick_q;
              wr_rep = (rd_rep == REP_MAX) ? rd_rep : rd_rep + 32'd1;
              status_d = ST_COALESCED; sres_d = rd_seq; state_d = FSM_TAIL;
            end else begin
              logic [AW-1:0] h;
              logic [CW-1:0] c;
              h = head_q; c = cnt_q;
              if (32'(cnt_q) >= 32'(QUEUE_DEPTH)) begin
                h = slot(head_q, CW'(1)); c = cnt_q - CW'(1);
              end
              wr_en = 1'b1; wr_full = 1'b1; wr_addr = slot(h, c);
              head_d = h; cnt_d = c + CW'(1);
              nseq_d = nseq_q + SEQ_BITS'(1);
              status_d = ST_QUEUED; sres_d = nseq_q; state_d = FSM_TRIM;
            end
          end
          MODE_EXPIRE: begin
            rd_en = 1'b1; rd_addr = head_q; state_d = FSM_EXPIRE;
          end
          MODE_CLEAR: begin
            cnt_d = '0; head_d = '0; state_d = FSM_TAIL;
          end
          default: state_d = FSM_TAIL;
        endcase
      end
      FSM_EXPIRE: begin
        // front entry data valid now
        if (cnt_q != '0 && rd_last < tick_q) begin
          head_d = slot(head_q, CW'(1)); cnt_d = cnt_q - CW'(1);
          rd_en = 1'b1; rd_addr = slot(head_q, CW'(1));
        end else begin
          state_d = FSM_TAIL;
        end
      end
      FSM_TRIM: begin
        if (cnt_q > cap_eff) begin
          head_d = slot(head_q, CW'(1)); cnt_d = cnt_q - CW'(1);
        end else begin
          state_d = FSM_TAIL;
        end
      end
      FSM_TAIL: begin
        rd_en = 1'b1; state_d = FSM_OUT;
      end
      FSM_OUT: state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
    if (accept) begin
      rd_en = 1'b1; state_d = FSM_READ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE; head_q <= '0; cnt_q <= '0; nseq_q <= SEQ_BITS'(1);
      cap_q <= 5'd16; win_q <= 16'd250; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; cnt_q <= cnt_d; nseq_q <= nseq_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CAPACITY) cap_q <= cfg_data_i[4:0];
        else win_q <= cfg_data_i;
      end
      if (state_q == FSM_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d; sres_q <= sres_d;
    if (accept) begin
      mode_q  <= s_axis_tdata[1:0];
      known_q <= s_axis_tdata[18];
      key_q   <= {s_axis_tdata[19 +: 4*KEY_BITS], s_axis_tdata[17:2]};
      tick_q  <= s_axis_tdata[19+4*KEY_BITS +: TICK_BITS];
    end
    if (state_q == FSM_OUT) begin
      odata_q <= {(cnt_q != '0) ? rd_rep : 32'd0,
                  (cnt_q != '0) ? rd_seq : SEQ_BITS'(0),
                  cnt_q != '0, cnt_q, sres_q, status_q};
    end
  end

  // assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(QUEUE_DEPTH)) else $error("count above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == FSM_IDLE && !ovalid_q) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q && $stable(odata_q))
    else $error("result dropped");
  a_trim_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_TAIL && mode_q == MODE_ENQ && status_q == ST_QUEUED |->
    cnt_q <= cap_eff) else $error("trim incomplete");

endmodule

[tb/tb_coalescing_event_queue.sv]
// self-checking testbench for the coalescing event queue
// directed table then random beats, checked against an in-bench predictor; uses ceq_pkg
`timescale 1ns / 1ps

module tb_coalescing_event_queue;
  import ceq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int IN_W      = 200;
  localparam int OUT_W     = 112;
  localparam int LIMIT     = 400000;
  localparam logic [31:0] REP_MAX = 32'hFFFF_FFFF;

  // highest field first, so status lands in the lowest bits
  typedef struct packed {
    logic [31:0] lrep;
    logic [31:0] lseq;
    logic        lvalid;
    logic [4:0]  count;
    logic [31:0] seq_res;
    logic [2:0]  status;
  } report_t;

  typedef struct packed {
    bit          chk;
    logic [2:0]  status;
    logic [4:0]  count;
  } pinned_t;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] pid;
    bit          known;
    logic [31:0] src, oth, vic, itm;
    logic [47:0] tick;
    bit          chk;
    logic [2:0]  status;
    logic [4:0]  count;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // mode, perception_id, perception_known, source, other, victim, item, tick_ms
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status, sequence_res, count, latest_valid, latest_sequence, latest_repeats
  logic [OUT_W-1:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  coalescing_event_queue i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // predictor state
  logic [31:0] q_seq   [DEPTH];
  logic [15:0] q_pid   [DEPTH];
  logic [31:0] q_src   [DEPTH];
  logic [31:0] q_oth   [DEPTH];
  logic [31:0] q_vic   [DEPTH];
  logic [31:0] q_itm   [DEPTH];
  logic [47:0] q_last  [DEPTH];
  logic [31:0] q_rep   [DEPTH];
  int unsigned q_head, q_cnt;
  logic [31:0] seq_next;
  logic [4:0]  cap_reg;
  logic [15:0] win_reg;

  report_t pending_reports [$];
  pinned_t pinned_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;
  int unsigned hold_req = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned slot(int unsigned pos);
    return (q_head + pos) % DEPTH;
  endfunction

  function automatic void pop_oldest();
    if (q_cnt != 0) begin
      q_head = (q_head + 1) % DEPTH;
      q_cnt--;
    end
  endfunction

  function automatic report_t predict_report(logic [IN_W-1:0] d);
    logic [1:0]  mode;
    logic [15:0] pid;
    logic        known;
    logic [31:0] src, oth, vic, itm;
    logic [47:0] tick;
    report_t     r;
    bit          merged;
    int unsigned s, cap;
    mode  = d[1:0];
    pid   = d[17:2];
    known = d[18];
    src   = d[50:19];
    oth   = d[82:51];
    vic   = d[114:83];
    itm   = d[146:115];
    tick  = d[194:147];
    r = '0;
    r.status = ST_DONE;
    if (mode == MODE_ENQ) begin
      if (!known) r.status = ST_UNKNOWN;
      else if (src == 0 && oth == 0 && vic == 0) r.status = ST_EMPTY;
      else begin
        merged = 1'b0;
        if (q_cnt != 0) begin
          s = slot(q_cnt - 1);
          if (q_pid[s] == pid && q_src[s] == src && q_oth[s] == oth &&
              q_vic[s] == vic && q_itm[s] == itm &&
              (tick <= q_last[s] || tick - q_last[s] <= {32'd0, win_reg})) begin
            q_last[s] = tick;
            if (q_rep[s] != REP_MAX) q_rep[s]++;
            r.status  = ST_COALESCED;
            r.seq_res = q_seq[s];
            merged    = 1'b1;
          end
        end
        if (!merged) begin
          cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : cap_reg;
          if (q_cnt >= DEPTH) pop_oldest();
          s = slot(q_cnt);
          q_seq[s] = seq_next;
          seq_next++;
          q_pid[s] = pid; q_src[s] = src; q_oth[s] = oth;
          q_vic[s] = vic; q_itm[s] = itm;
          q_last[s] = tick; q_rep[s] = 1;
          q_cnt++;
          while (q_cnt > cap) pop_oldest();
          r.status  = ST_QUEUED;
          r.seq_res = q_seq[s];
        end
      end
    end else if (mode == MODE_EXPIRE) begin
      while (q_cnt != 0 && q_last[slot(0)] < tick) pop_oldest();
    end else if (mode == MODE_CLEAR) begin
      q_cnt = 0;
      q_head = 0;
    end
    r.count = q_cnt[4:0];
    if (q_cnt != 0) begin
      s = slot(q_cnt - 1);
      r.lvalid = 1'b1;
      r.lseq   = q_seq[s];
      r.lrep   = q_rep[s];
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_beat(logic [1:0] mode, logic [15:0] pid,
      logic known, logic [31:0] src, logic [31:0] oth, logic [31:0] vic,
      logic [31:0] itm, logic [47:0] tick);
    return {5'd0, tick, itm, vic, oth, src, known, pid, mode};
  endfunction

  // input side: every accepted beat gets its expected report
  always @(posedge clk_i) begin
    pinned_t p;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_reports = {pending_reports, predict_report(s_axis_tdata)};
      p = '0;
      if (pinned_q.size() != 0) begin
        p = pinned_q[0];
        pinned_q.delete(0);
      end
      if (p.chk) begin
        // table status and count replace what the predictor computed
        pending_reports[$].status = p.status;
        pending_reports[$].count  = p.count;
      end
    end
  end

  // output side: compare each report beat with the oldest expectation
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[104:0];
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report beat %h", got);
      end else begin
        want = pending_reports[0];
        pending_reports.delete(0);
        if (got != want) begin
          errors++;
          if (errors <= 10) begin
            $display("report mismatch: exp st=%0d seq=%0d cnt=%0d lv=%0d lseq=%0d lrep=%0d",
                     want.status, want.seq_res, want.count, want.lvalid, want.lseq,
                     want.lrep);
            $display("                 got st=%0d seq=%0d cnt=%0d lv=%0d lseq=%0d lrep=%0d",
                     got.status, got.seq_res, got.count, got.lvalid, got.lseq, got.lrep);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_req <= hold_req - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(logic [IN_W-1:0] d, pinned_t p);
    if (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    pinned_q = {pinned_q, p};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CAPACITY) cap_reg = val[4:0];
    else win_reg = val;
    @(posedge clk_i);
  endtask

  // random beat, mostly enqueues that repeat the newest event near its tick
  logic [15:0] last_pid;
  logic [31:0] last_src, last_oth, last_vic, last_itm;
  logic [47:0] last_tick;

  task automatic random_beat();
    int unsigned pick;
    logic [1:0]  mode;
    logic [15:0] pid;
    logic        known;
    logic [31:0] src, oth, vic, itm;
    logic [47:0] tick;
    pick = $urandom_range(99);
    mode = (pick < 72) ? MODE_ENQ : (pick < 84) ? MODE_EXPIRE :
           (pick < 88) ? MODE_CLEAR : MODE_QUERY;
    known = ($urandom_range(99) < 90);
    if ($urandom_range(99) < 55) begin
      pid = last_pid; src = last_src; oth = last_oth; vic = last_vic; itm = last_itm;
    end else begin
      pid = 16'($urandom);
      src = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      oth = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      vic = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      itm = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 4) tick = 48'({$urandom, $urandom});
    else if (pick < 8) tick = 48'hFFFF_FFFF_FFFF - $urandom_range(300);
    else if (pick < 20) tick = last_tick - $urandom_range(100);
    else tick = last_tick + $urandom_range(win_reg + 64);
    if (mode == MODE_ENQ && known) begin
      last_pid = pid; last_src = src; last_oth = oth; last_vic = vic; last_itm = itm;
      last_tick = tick;
    end
    if (mode == MODE_EXPIRE && $urandom_range(1)) tick = last_tick - $urandom_range(800);
    send_beat(pack_beat(mode, pid, known, src, oth, vic, itm, tick), '0);
  endtask

  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  dir_row_t dir_tab [17] = '{
    '{MODE_QUERY,  16'h0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 48'd0, 1'b1, ST_DONE, 5'd0},
    '{MODE_ENQ,    16'h1234, 1'b0, 32'h1, 32'h2, 32'h3, 32'h4, 48'd5, 1'b1, ST_UNKNOWN, 5'd0},
    '{MODE_ENQ,    16'h1234, 1'b1, 32'h0, 32'h0, 32'h0, 32'h9, 48'd5, 1'b1, ST_EMPTY, 5'd0},
    '{MODE_ENQ,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 48'd100, 1'b1, ST_QUEUED, 5'd1},
    '{MODE_ENQ,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 48'd350, 1'b1, ST_COALESCED, 5'd1},
    '{MODE_ENQ,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 48'd601, 1'b1, ST_QUEUED, 5'd2},
    '{MODE_ENQ,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 48'd10, 1'b1, ST_COALESCED, 5'd2},
    '{MODE_ENQ,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h0, 48'd700, 1'b1, ST_QUEUED, 5'd3},
    '{MODE_EXPIRE, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 48'd0, 1'b1, ST_DONE, 5'd3},
    '{MODE_EXPIRE, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 48'd400, 1'b1, ST_DONE, 5'd1},
    '{MODE_CLEAR,  16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 48'd0, 1'b1, ST_DONE, 5'd0},
    '{MODE_ENQ,    16'h0000, 1'b1, 32'h1, 32'h0, 32'h0, 32'h0, TMAX, 1'b1, ST_QUEUED, 5'd1},
    '{MODE_ENQ,    16'h0000, 1'b1, 32'h1, 32'h0, 32'h0, 32'h0, TMAX, 1'b1, ST_COALESCED, 5'd1},
    '{MODE_QUERY,  16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, TMAX, 1'b1, ST_DONE, 5'd1},
    '{MODE_EXPIRE, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, TMAX, 1'b1, ST_DONE, 5'd1},
    '{MODE_ENQ,    16'h8000, 1'b1, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 48'd0, 1'b1,
      ST_QUEUED, 5'd2},
    '{MODE_ENQ,    16'h8000, 1'b1, 32'h0, 32'h0, 32'h8000_0000, 32'h1, 48'h8000_0000_0000,
      1'b0, ST_DONE, 5'd0}
  };

  // capacity and window for each random phase
  logic [15:0] phase_cap [6] = '{16'd3, 16'd0, 16'd31, 16'd1, 16'd40, 16'd16};
  logic [15:0] phase_win [6] = '{16'd100, 16'd0, 16'd65535, 16'd65535, 16'd7, 16'd250};

  initial begin
    pinned_t p;
    q_head = 0; q_cnt = 0; seq_next = 32'd1;
    cap_reg = 5'd16; win_reg = 16'd250;
    last_pid = 16'h55; last_src = 32'h1; last_oth = 32'h0; last_vic = 32'h0;
    last_itm = 32'h0; last_tick = 48'd1000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      p.chk = dir_tab[k].chk; p.status = dir_tab[k].status; p.count = dir_tab[k].count;
      send_beat(pack_beat(dir_tab[k].mode, dir_tab[k].pid, dir_tab[k].known,
                          dir_tab[k].src, dir_tab[k].oth, dir_tab[k].vic,
                          dir_tab[k].itm, dir_tab[k].tick), p);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_CAPACITY, phase_cap[ph]);
      write_cfg(CFG_WINDOW, phase_win[ph]);
      calm = (ph == 3);
      if (ph == 2) hold_req = 300;
      for (int n = 0; n < 100; n++) random_beat();
      drain();
    end
    calm = 1'b0;

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
